// ===== rtl/core/mi4_pkg.sv =====
// shared types, constants and index helpers for the 4x4 matrix inverse
// no dependencies
package mi4_pkg;

  // digit width of the shared multiplier
  localparam int DIGIT_W = 16;

  typedef enum logic [3:0] {
    S_LOAD,  // take sixteen elements
    S_RDX,   // read first factor
    S_RDY,   // read second factor
    S_M1,    // first product
    S_W1,
    S_M2,    // second product
    S_W2,    // accumulate term
    S_DRD,   // determinant reads
    S_DM,
    S_DW,
    S_DIVS,  // reciprocal start
    S_DIVW,
    S_ORD,   // output reads
    S_OM,
    S_OW,
    S_OH     // result waits for the sink
  } mi4_state_t;

  // element address of factor f of term t of pair p, adjugate entry (ci, rj)
  function automatic logic [3:0] elem_addr(input logic [1:0] ci, input logic [1:0] rj,
                                           input logic [1:0] p, input logic t,
                                           input logic [1:0] f);
    logic [1:0] r0, r1, r2, c0, c1, c2, k, a, b, row, col;
    r0 = (2'd0 < rj) ? 2'd0 : 2'd1;
    r1 = (2'd1 < rj) ? 2'd1 : 2'd2;
    r2 = (2'd2 < rj) ? 2'd2 : 2'd3;
    c0 = (2'd0 < ci) ? 2'd0 : 2'd1;
    c1 = (2'd1 < ci) ? 2'd1 : 2'd2;
    c2 = (2'd2 < ci) ? 2'd2 : 2'd3;
    k = (p == 2'd0) ? r0 : ((p == 2'd1) ? r1 : r2);
    a = (p == 2'd0) ? r1 : r0;
    b = (p == 2'd2) ? r1 : r2;
    case (f)
      2'd0: begin
        row = k;
        col = c0;
      end
      2'd1: begin
        row = a;
        col = t ? c2 : c1;
      end
      default: begin
        row = b;
        col = t ? c1 : c2;
      end
    endcase
    return {row, col};
  endfunction

endpackage

// ===== rtl/core/mi4_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module mi4_ram #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/mi4_mul.sv =====
// shared multiplier: exact signed product over digit steps, floor shift, saturate
// depends on mi4_pkg
module mi4_mul #(
  parameter int MW = 48,
  parameter int FB = 16,
  parameter int WW = 48,
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 narrow,   // saturate to element width
  input  logic signed [MW-1:0] a,
  input  logic signed [MW-1:0] b,
  output logic                 done,
  output logic signed [MW-1:0] result
);

  localparam int DW = mi4_pkg::DIGIT_W;
  localparam int ND = (MW + DW - 1) / DW;
  localparam int BW = ND * DW;
  localparam int PW = MW + BW + 1;
  localparam int KW = $clog2(ND + 1);
  localparam logic signed [PW-1:0] WMAX = {{(PW-WW+1){1'b0}}, {(WW-1){1'b1}}};
  localparam logic signed [PW-1:0] WMIN = ~WMAX;
  localparam logic signed [PW-1:0] EMAX = {{(PW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [PW-1:0] EMIN = ~EMAX;

  logic signed [MW-1:0]    a_r;
  logic [BW-1:0]           b_r;
  logic signed [PW-1:0]    acc_r;
  logic [KW-1:0]           k_r;
  logic                    busy_r, fin_r, done_r, narrow_r;
  logic signed [MW-1:0]    res_r;
  logic signed [DW:0]      digit;
  logic signed [MW+DW:0]   pp;
  logic signed [PW-1:0]    shifted, lim_hi, lim_lo, clamped;

  // top digit signed, lower digits unsigned, taken most significant first
  always_comb begin
    digit = (k_r == '0) ? {b_r[BW-1], b_r[BW-1 -: DW]} : {1'b0, b_r[BW-1 -: DW]};
    pp = a_r * digit;
    shifted = acc_r >>> FB;
    lim_hi = narrow_r ? EMAX : WMAX;
    lim_lo = narrow_r ? EMIN : WMIN;
    if (shifted > lim_hi) begin
      clamped = lim_hi;
    end else if (shifted < lim_lo) begin
      clamped = lim_lo;
    end else begin
      clamped = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r      <= a;
        b_r      <= BW'(b);
        acc_r    <= '0;
        k_r      <= '0;
        narrow_r <= narrow;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        acc_r <= (acc_r <<< DW) + PW'(pp);
        b_r   <= b_r << DW;
        k_r   <= k_r + 1'b1;
        if (k_r == KW'(ND - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        res_r  <= clamped[MW-1:0];
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

// ===== rtl/core/mi4_div.sv =====
// restoring divider for the reciprocal floor(2^(2*FB)/den), saturated to EW bits
// no dependencies
module mi4_div #(
  parameter int WW = 48,
  parameter int FB = 16,
  parameter int EW = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [WW-1:0] den,    // nonzero
  output logic                 done,
  output logic signed [EW-1:0] recip
);

  localparam int NB = 2 * FB + 1;
  localparam int CW = $clog2(NB + 1);
  localparam int RW = NB + EW + 1;
  localparam logic signed [RW-1:0] EMAX = {{(RW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [RW-1:0] EMIN = ~EMAX;

  logic [WW-1:0]        ud_r, rem_r;
  logic [NB-1:0]        q_r, num_r;
  logic [CW-1:0]        cnt_r;
  logic                 neg_r, busy_r, fin_r, done_r;
  logic signed [EW-1:0] res_r;
  logic [WW:0]          rs, diff, neg_den;
  logic                 ge;
  logic signed [RW-1:0] qe, rv, clamped;

  always_comb begin
    neg_den = (WW+1)'(0) - {den[WW-1], den};
    rs   = {rem_r, num_r[NB-1]};
    diff = rs - {1'b0, ud_r};
    ge   = (rs >= {1'b0, ud_r});
    qe   = RW'({1'b0, q_r});
    rv   = neg_r ? (-qe - RW'(rem_r != '0)) : qe;
    if (rv > EMAX) begin
      clamped = EMAX;
    end else if (rv < EMIN) begin
      clamped = EMIN;
    end else begin
      clamped = rv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        neg_r  <= den[WW-1];
        ud_r   <= den[WW-1] ? neg_den[WW-1:0] : den;
        rem_r  <= '0;
        q_r    <= '0;
        num_r  <= {1'b1, {(NB-1){1'b0}}};
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[WW-1:0] : rs[WW-1:0];
        q_r   <= {q_r[NB-2:0], ge};
        num_r <= num_r << 1;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NB - 1)) begin
          busy_r <= 1'b0;
          fin_r  <= 1'b1;
        end
      end else if (fin_r) begin
        res_r  <= clamped[EW-1:0];
        fin_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign recip = res_r;

endmodule

// ===== rtl/core/matrix_inverse_4x4.sv =====
// top level of the 4x4 fixed-point matrix inverse by cofactors and adjugate
// depends on mi4_pkg, mi4_ram, mi4_mul, mi4_div
//
// Sixteen elements enter row-major, one request per cycle, while in_tready
// is high. After the sixteenth the block drops in_tready, builds the
// adjugate from 96 three-factor products, the determinant from the first
// row, and the reciprocal, then sends sixteen row-major results; in_tready
// returns after the sixteenth result is taken. Every product goes through
// one shared multiplier that steps over 16-bit digits of its second operand
// (three steps at default widths), the reciprocal comes from a bit-serial
// divider, and each result is held while the sink stalls. A zero
// determinant gives the identity with out_tuser set.
module matrix_inverse_4x4 #(
  parameter int ELEMENT_WIDTH = 32,
  parameter int FRACTION_BITS = 16,
  parameter int WORK_WIDTH    = 48
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((ELEMENT_WIDTH+7)/8)*8-1:0]    in_tdata,   // element_value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [((ELEMENT_WIDTH+7)/8)*8-1:0]    out_tdata,  // inverse_value
  output logic [0:0]                            out_tuser,  // singular
  output logic                                  out_tlast   // last_element
);

  localparam int EW  = ELEMENT_WIDTH;
  localparam int FB  = FRACTION_BITS;
  localparam int WW  = WORK_WIDTH;
  localparam int TDW = ((EW + 7) / 8) * 8;
  localparam int MW  = (EW > WW) ? EW : WW;
  localparam logic signed [EW-1:0] IDENT =
    (FB >= EW - 1) ? {1'b0, {(EW-1){1'b1}}} : (EW'(1) << FB);

  // saturating add result to work width
  function automatic logic signed [WW-1:0] sat_ww(input logic signed [WW:0] v);
    logic signed [WW-1:0] r;
    if (v[WW] != v[WW-1]) begin
      r = v[WW] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
    end else begin
      r = v[WW-1:0];
    end
    return r;
  endfunction

  mi4_pkg::mi4_state_t state_r, state_nxt;

  logic [3:0]           cnt_r;      // elements loaded
  logic [3:0]           e_r;        // adjugate entry / det column / output index
  logic [1:0]           p_r;        // term pair
  logic                 t_r;        // term within pair
  logic signed [EW-1:0] hold_r;     // first factor
  logic signed [WW-1:0] acc_r, det_r;
  logic signed [EW-1:0] recip_r;
  logic                 singular_r;
  logic                 out_valid_r, out_last_r;
  logic signed [EW-1:0] out_val_r;

  // ram and unit controls
  logic                 el_re, cf_re, cf_we, mul_start, mul_narrow, div_start;
  logic [3:0]           el_raddr, cf_raddr;
  logic [1:0]           fsel;
  logic [EW-1:0]        el_rdata;
  logic [WW-1:0]        cf_rdata;
  logic signed [MW-1:0] mul_a, mul_b, mul_res;
  logic                 mul_done, div_done;
  logic signed [EW-1:0] div_res;
  logic                 in_acc, out_acc, term_sub, last_term;
  logic signed [WW-1:0] acc_sum, det_sum;

  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_valid_r && out_tready;
  assign term_sub  = ~((~(e_r[2] ^ e_r[0] ^ p_r[0])) ^ t_r);
  assign last_term = t_r && (p_r == 2'd2);
  assign acc_sum   = term_sub ? sat_ww({acc_r[WW-1], acc_r} - {mul_res[WW-1], mul_res[WW-1:0]})
                              : sat_ww({acc_r[WW-1], acc_r} + {mul_res[WW-1], mul_res[WW-1:0]});
  assign det_sum   = sat_ww({det_r[WW-1], det_r} + {mul_res[WW-1], mul_res[WW-1:0]});

  mi4_ram #(.DATA_W(EW), .DEPTH(16)) u_elem_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (cnt_r),
    .wdata (in_tdata[EW-1:0]),
    .re    (el_re),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  mi4_ram #(.DATA_W(WW), .DEPTH(16)) u_cof_ram (
    .clk   (clk),
    .we    (cf_we),
    .waddr (e_r),
    .wdata (acc_sum),
    .re    (cf_re),
    .raddr (cf_raddr),
    .rdata (cf_rdata)
  );

  mi4_mul #(.MW(MW), .FB(FB), .WW(WW), .EW(EW)) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .narrow (mul_narrow),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  mi4_div #(.WW(WW), .FB(FB), .EW(EW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .den   (det_r),
    .done  (div_done),
    .recip (div_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mi4_pkg::S_LOAD: if (in_acc && cnt_r == 4'd15) state_nxt = mi4_pkg::S_RDX;
      mi4_pkg::S_RDX:  state_nxt = mi4_pkg::S_RDY;
      mi4_pkg::S_RDY:  state_nxt = mi4_pkg::S_M1;
      mi4_pkg::S_M1:   state_nxt = mi4_pkg::S_W1;
      mi4_pkg::S_W1:   if (mul_done) state_nxt = mi4_pkg::S_M2;
      mi4_pkg::S_M2:   state_nxt = mi4_pkg::S_W2;
      mi4_pkg::S_W2: begin
        if (mul_done) begin
          state_nxt = (last_term && e_r == 4'd15) ? mi4_pkg::S_DRD : mi4_pkg::S_RDX;
        end
      end
      mi4_pkg::S_DRD:  state_nxt = mi4_pkg::S_DM;
      mi4_pkg::S_DM:   state_nxt = mi4_pkg::S_DW;
      mi4_pkg::S_DW: begin
        if (mul_done) state_nxt = (e_r == 4'd3) ? mi4_pkg::S_DIVS : mi4_pkg::S_DRD;
      end
      mi4_pkg::S_DIVS: state_nxt = (det_r == '0) ? mi4_pkg::S_ORD : mi4_pkg::S_DIVW;
      mi4_pkg::S_DIVW: if (div_done) state_nxt = mi4_pkg::S_ORD;
      mi4_pkg::S_ORD:  state_nxt = mi4_pkg::S_OM;
      mi4_pkg::S_OM:   state_nxt = singular_r ? mi4_pkg::S_OH : mi4_pkg::S_OW;
      mi4_pkg::S_OW:   if (mul_done) state_nxt = mi4_pkg::S_OH;
      mi4_pkg::S_OH: begin
        if (out_acc) state_nxt = (e_r == 4'd15) ? mi4_pkg::S_LOAD : mi4_pkg::S_ORD;
      end
      default:         state_nxt = mi4_pkg::S_LOAD;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready  = 1'b0;
    el_re      = 1'b0;
    cf_re      = 1'b0;
    cf_we      = 1'b0;
    mul_start  = 1'b0;
    mul_narrow = 1'b0;
    div_start  = 1'b0;
    fsel       = 2'd0;
    cf_raddr   = e_r;
    mul_a      = MW'(hold_r);
    mul_b      = MW'($signed(el_rdata));
    case (state_r)
      mi4_pkg::S_LOAD: in_tready = 1'b1;
      mi4_pkg::S_RDX:  el_re = 1'b1;
      mi4_pkg::S_RDY: begin
        el_re = 1'b1;
        fsel  = 2'd1;
      end
      mi4_pkg::S_M1: begin
        el_re     = 1'b1;
        fsel      = 2'd2;
        mul_start = 1'b1;
      end
      mi4_pkg::S_M2: begin
        mul_start = 1'b1;
        mul_a     = mul_res;
      end
      mi4_pkg::S_W2:   cf_we = mul_done && last_term;
      mi4_pkg::S_DRD: begin
        el_re    = 1'b1;
        cf_re    = 1'b1;
        cf_raddr = {e_r[1:0], 2'b00};
      end
      mi4_pkg::S_DM: begin
        mul_start = 1'b1;
        mul_a     = MW'($signed(el_rdata));
        mul_b     = MW'($signed(cf_rdata));
      end
      mi4_pkg::S_DIVS: div_start = (det_r != '0);
      mi4_pkg::S_ORD:  cf_re = 1'b1;
      mi4_pkg::S_OM: begin
        mul_start  = !singular_r;
        mul_narrow = 1'b1;
        mul_a      = MW'($signed(cf_rdata));
        mul_b      = MW'(recip_r);
      end
      default: ;
    endcase
    el_raddr = mi4_pkg::elem_addr(e_r[3:2], e_r[1:0], p_r, t_r, fsel);
    if (state_r == mi4_pkg::S_DRD) begin
      el_raddr = {2'b00, e_r[1:0]};
    end
  end

  // sequencer registers and datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mi4_pkg::S_LOAD;
      cnt_r       <= '0;
      e_r         <= '0;
      p_r         <= '0;
      t_r         <= 1'b0;
      acc_r       <= '0;
      det_r       <= '0;
      singular_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        mi4_pkg::S_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_r + 1'b1;
          end
          e_r   <= '0;
          p_r   <= '0;
          t_r   <= 1'b0;
          acc_r <= '0;
        end
        mi4_pkg::S_RDY:  hold_r <= el_rdata;
        mi4_pkg::S_W2: begin
          if (mul_done) begin
            if (!t_r) begin
              t_r   <= 1'b1;
              acc_r <= acc_sum;
            end else if (p_r != 2'd2) begin
              t_r   <= 1'b0;
              p_r   <= p_r + 1'b1;
              acc_r <= acc_sum;
            end else begin
              // entry finished and written to the cofactor ram
              t_r   <= 1'b0;
              p_r   <= '0;
              acc_r <= '0;
              e_r   <= e_r + 1'b1;
              det_r <= '0;
            end
          end
        end
        mi4_pkg::S_DW: begin
          if (mul_done) begin
            det_r <= det_sum;
            e_r   <= (e_r == 4'd3) ? 4'd0 : e_r + 1'b1;
          end
        end
        mi4_pkg::S_DIVS: singular_r <= (det_r == '0);
        mi4_pkg::S_DIVW: if (div_done) recip_r <= div_res;
        mi4_pkg::S_OM: begin
          out_last_r <= (e_r == 4'd15);
          if (singular_r) begin
            out_val_r   <= (e_r[1:0] == e_r[3:2]) ? IDENT : '0;
            out_valid_r <= 1'b1;
          end
        end
        mi4_pkg::S_OW: begin
          if (mul_done) begin
            out_val_r   <= mul_res[EW-1:0];
            out_valid_r <= 1'b1;
          end
        end
        mi4_pkg::S_OH: begin
          if (out_acc) begin
            out_valid_r <= 1'b0;
            e_r         <= e_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'($unsigned(out_val_r));
  assign out_tuser  = singular_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== dv/matrix_inverse_4x4_tb.sv =====
// self-checking testbench for matrix_inverse_4x4: streams whole 4x4 matrices in,
// predicts the sixteen inverse results of each one and checks them in order
// depends on the rtl top level matrix_inverse_4x4 and mi4_pkg
`timescale 1ns / 1ps

module matrix_inverse_4x4_tb;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int WW = 48;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD = 3000;
  localparam logic [EW-1:0] ONE_Q = 32'h0001_0000;
  localparam logic [EW-1:0] MAX_Q = 32'h7fff_ffff;
  localparam logic [EW-1:0] MIN_Q = 32'h8000_0000;

  typedef struct {
    logic [EW-1:0] value;
    bit            singular;
    bit            last;
  } inv_result_t;

  // one directed matrix; known rows carry a result read off by hand
  typedef struct {
    logic [EW-1:0] elems [16];
    bit            known;
    bit            known_singular;
  } matrix_row_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [31:0]   in_tdata = '0;   // element_value
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [31:0]   out_tdata;       // inverse_value
  logic [0:0]    out_tuser;       // singular
  logic          out_tlast;       // last_element

  inv_result_t   pending_inverse [$];
  logic [EW-1:0] loaded [16];
  int            load_idx = 0;
  bit            known_now = 0;
  bit            known_sing_now = 0;
  int            errors = 0;
  int            idle_cycles = 0;
  bit            quiet = 0;        // no random idling on either side
  bit            hold_request = 0; // sender asks the sink for one long hold-off

  matrix_inverse_4x4 DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------

  // saturate a wide value to w signed bits
  function automatic longint clamp_bits(logic signed [127:0] v, int w);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return longint'(hi);
    if (v < lo) return longint'(lo);
    return longint'(v);
  endfunction

  // exact product, floor shift by the fraction width, saturate
  function automatic longint fx_mul(longint a, longint b, int w);
    logic signed [127:0] pa, pb, prod;
    pa = a;
    pb = b;
    prod = (pa * pb) >>> FB;
    return clamp_bits(prod, w);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return clamp_bits(pa + pb, WW);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    logic signed [127:0] pa, pb;
    pa = a;
    pb = b;
    return clamp_bits(pa - pb, WW);
  endfunction

  function automatic longint elem_at(int r, int c);
    return longint'($signed(loaded[(r * 4 + c) % 16]));
  endfunction

  // cofactor of element (j,i), which lands at adjugate (i,j)
  function automatic longint cofactor(int i, int j);
    int rows [3];
    int cols [3];
    int nr, nc, k, a, b;
    longint acc, t1, t2;
    nr = 0;
    nc = 0;
    acc = 0;
    for (int t = 0; t < 4; t++) begin
      if (t != j) begin
        rows[nr] = t;
        nr++;
      end
      if (t != i) begin
        cols[nc] = t;
        nc++;
      end
    end
    for (int p = 0; p < 3; p++) begin
      k = rows[p];
      a = rows[(p == 0) ? 1 : 0];
      b = rows[(p == 2) ? 1 : 2];
      // magnitudes first, sign applied by add or subtract
      t1 = fx_mul(fx_mul(elem_at(k, cols[0]), elem_at(a, cols[1]), WW), elem_at(b, cols[2]), WW);
      t2 = fx_mul(fx_mul(elem_at(k, cols[0]), elem_at(a, cols[2]), WW), elem_at(b, cols[1]), WW);
      if (((i + j + p) % 2) == 0) begin
        acc = fx_add(acc, t1);
        acc = fx_sub(acc, t2);
      end else begin
        acc = fx_sub(acc, t1);
        acc = fx_add(acc, t2);
      end
    end
    return acc;
  endfunction

  // floor(2^(2F)/det), saturated to the element width
  function automatic longint recip_of(longint det);
    longint mag, q, r, res;
    mag = (det < 0) ? -det : det;
    q = (64'sd1 <<< (2 * FB)) / mag;
    r = (64'sd1 <<< (2 * FB)) % mag;
    res = (det > 0) ? q : (-q - ((r != 0) ? 1 : 0));
    return clamp_bits(res, EW);
  endfunction

  // predict the sixteen results of the matrix now in loaded[]
  task automatic predict_inverse();
    longint adj [16];
    longint det, rcp;
    inv_result_t res;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        adj[i * 4 + j] = cofactor(i, j);
    det = 0;
    for (int j = 0; j < 4; j++)
      det = fx_add(det, fx_mul(elem_at(0, j), adj[j * 4], WW));
    rcp = (det != 0) ? recip_of(det) : 0;
    for (int n = 0; n < 16; n++) begin
      res.singular = (det == 0);
      res.last = (n == 15);
      if (det == 0) res.value = ((n % 5) == 0) ? ONE_Q : '0;
      else res.value = EW'(fx_mul(adj[n], rcp, EW));
      pending_inverse.push_back(res);
    end
  endtask

  // identity result typed in for directed rows with an obvious answer
  task automatic push_identity(bit sing);
    inv_result_t res;
    for (int n = 0; n < 16; n++) begin
      res.value = ((n % 5) == 0) ? ONE_Q : '0;
      res.singular = sing;
      res.last = (n == 15);
      pending_inverse.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------
  // sender: one element request, random gaps on the falling edge
  // ---------------------------------------------------------------------
  task automatic send_element(logic [EW-1:0] v);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 17) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = v;
    do @(posedge clk); while (!in_tready);
    loaded[load_idx] = v;
    load_idx = (load_idx + 1) % 16;
    if (load_idx == 0) begin
      if (known_now) push_identity(known_sing_now);
      else predict_inverse();
    end
  endtask

  task automatic send_matrix(logic [EW-1:0] m [16], bit known, bit sing);
    known_now = known;
    known_sing_now = sing;
    for (int n = 0; n < 16; n++) send_element(m[n]);
  endtask

  function automatic logic [EW-1:0] small_q(int range_units);
    return EW'($signed($urandom_range(2 * (range_units << FB))) - (range_units << FB));
  endfunction

  // random matrix of one of several shapes
  task automatic make_random(output logic [EW-1:0] m [16]);
    int kind, zc;
    kind = $urandom_range(5);
    zc = $urandom_range(3);
    for (int n = 0; n < 16; n++) begin
      case (kind)
        0: m[n] = $urandom;                                  // full range
        1: m[n] = small_q(4);                                // well scaled
        2: m[n] = (n % 5 == 0) ? EW'((8 + $urandom_range(8)) << FB) : small_q(1);
        3: m[n] = ((n % 4) == zc) ? '0 : small_q(8);         // zero column
        4: m[n] = (n % 5 == 0) ? EW'($urandom_range(1, 3)) : '0; // tiny det
        default: begin                                        // extremes mix
          case ($urandom_range(5))
            0: m[n] = MAX_Q;
            1: m[n] = MIN_Q;
            2: m[n] = '0;
            3: m[n] = ONE_Q;
            4: m[n] = -ONE_Q;
            default: m[n] = $urandom;
          endcase
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------
  // sink: random back-pressure plus one long hold-off
  // ---------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready = 1'b0;
      end else begin
        out_tready = quiet ? 1'b1 : ($urandom_range(99) >= 17);
      end
    end
  end

  // result checker, sampled on the rising edge
  always @(posedge clk) begin
    inv_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_inverse.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, out_tdata);
      end else begin
        want = pending_inverse.pop_front();
        if (out_tdata !== want.value) begin
          errors++;
          $display("%0t: inverse_value expected %h actual %h", $time, want.value, out_tdata);
        end
        if (out_tuser[0] !== want.singular) begin
          errors++;
          $display("%0t: singular expected %b actual %b", $time, want.singular, out_tuser[0]);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $display("%0t: last_element expected %b actual %b", $time, want.last, out_tlast);
        end
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("matrix_inverse_4x4_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------
  initial begin
    matrix_row_t   directed [3];
    logic [EW-1:0] m [16];
    int            guard;

    // zero matrix gives the identity with singular set
    for (int n = 0; n < 16; n++) directed[0].elems[n] = '0;
    directed[0].known = 1;
    directed[0].known_singular = 1;
    // identity is its own inverse
    for (int n = 0; n < 16; n++) directed[1].elems[n] = ((n % 5) == 0) ? ONE_Q : '0;
    directed[1].known = 1;
    directed[1].known_singular = 0;
    // extremes of the element field, saturating everywhere
    directed[2].elems = '{MAX_Q, MIN_Q, 32'h0000_0001, 32'hffff_ffff,
                          MIN_Q, MAX_Q, ONE_Q, -ONE_Q,
                          32'h0000_0001, ONE_Q, MAX_Q, '0,
                          32'hffff_ffff, -ONE_Q, '0, MIN_Q};
    directed[2].known = 0;
    directed[2].known_singular = 0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[r]) send_matrix(directed[r].elems, directed[r].known,
                                      directed[r].known_singular);

    for (int k = 0; k < 8; k++) begin
      quiet = (k == 6 || k == 7);
      if (k == 3) hold_request = 1;
      make_random(m);
      send_matrix(m, 0, 0);
    end
    @(negedge clk);
    in_tvalid = 1'b0;
    quiet = 0;

    guard = 0;
    while (pending_inverse.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (50) @(posedge clk);

    if (errors == 0 && pending_inverse.size() == 0) begin
      $display("matrix_inverse_4x4_tb passed");
    end else begin
      $display("matrix_inverse_4x4_tb failed");
    end
    $finish;
  end

endmodule
